FILE: src/spq_pkg.sv
// Shared constants, status codes and the stored entry type for the sorted priority queue.
// Used by the channel interfaces and every module of the block; depends on nothing.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int VALUE_W      = 32;
	localparam int PRIO_W       = 16;
	localparam int STATUS_W     = 2;
	localparam int CAPACITY_DEF = 16;

	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic signed [PRIO_W-1:0]  prio;
	} spq_entry_t;

endpackage

FILE: src/spq_if.sv
// Request and response channel interfaces of the sorted priority queue.
// Depends on spq_pkg for field widths and the default capacity.
`timescale 1ns / 1ps

interface spq_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 kind;
	logic signed [spq_pkg::VALUE_W-1:0]   value_in;
	logic signed [spq_pkg::PRIO_W-1:0]    priority_in;

	modport source (output valid, kind, value_in, priority_in, input ready);
	modport sink   (input valid, kind, value_in, priority_in, output ready);
endinterface

interface spq_rsp_if #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
);
	localparam int OCC_W = $clog2(CAPACITY + 1);

	logic                                 valid;
	logic                                 ready;
	logic signed [spq_pkg::VALUE_W-1:0]   value_out;
	logic [spq_pkg::STATUS_W-1:0]         status;
	logic [OCC_W-1:0]                     occupancy;

	modport source (output valid, value_out, status, occupancy, input ready);
	modport sink   (input valid, value_out, status, occupancy, output ready);
endinterface

FILE: src/spq_store.sv
// Entry storage of the sorted priority queue: one write port, one read port, registered read.
// Depends on spq_pkg for the entry type.
`timescale 1ns / 1ps

module spq_store #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
	localparam int IDX_W   = $clog2(CAPACITY)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_addr,
	input  spq_pkg::spq_entry_t wr_data,
	input  logic                rd_en,
	input  logic [IDX_W-1:0]    rd_addr,
	output spq_pkg::spq_entry_t rd_data
);

	spq_pkg::spq_entry_t mem_q [CAPACITY];
	spq_pkg::spq_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/spq_seq.sv
// Sequencer of the sorted priority queue: walks the stored list one slot at a time
// through the single priority comparator and owns the response register.
// Depends on spq_pkg and the channel interfaces in spq_if.sv.
`timescale 1ns / 1ps

module spq_seq #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
	localparam int IDX_W   = $clog2(CAPACITY),
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	spq_req_if.sink             req,
	spq_rsp_if.source           rsp,
	output logic                wr_en,
	output logic [IDX_W-1:0]    wr_addr,
	output spq_pkg::spq_entry_t wr_data,
	output logic                rd_en,
	output logic [IDX_W-1:0]    rd_addr,
	input  spq_pkg::spq_entry_t rd_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EWALK = 3'd1;
	localparam logic [2:0] S_ECMP  = 3'd2;
	localparam logic [2:0] S_DREAD = 3'd3;
	localparam logic [2:0] S_DWALK = 3'd4;
	localparam logic [2:0] S_DMOVE = 3'd5;
	localparam logic [2:0] S_RESP  = 3'd6;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [2:0]                          state_q;
	logic [CNT_W-1:0]                    count_q;
	logic [IDX_W-1:0]                    idx_q;
	spq_pkg::spq_entry_t                 new_q;
	logic signed [spq_pkg::VALUE_W-1:0]  res_value_q;
	logic [spq_pkg::STATUS_W-1:0]        res_status_q;
	logic                                rsp_valid_q;
	logic signed [spq_pkg::VALUE_W-1:0]  rsp_value_q;
	logic [spq_pkg::STATUS_W-1:0]        rsp_status_q;
	logic [CNT_W-1:0]                    rsp_occ_q;

	logic             accept;
	logic             load;
	logic             greater;
	logic [CNT_W-1:0] idx_next_cnt;
	logic             shift_done;

	assign req.ready     = (state_q == S_IDLE);
	assign accept        = req.valid && req.ready;
	assign load          = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);
	assign greater       = (rd_data.prio > new_q.prio);
	assign idx_next_cnt  = CNT_W'(idx_q) + CNT_W'(1);
	assign shift_done    = (idx_next_cnt >= count_q);

	assign rsp.valid     = rsp_valid_q;
	assign rsp.value_out = rsp_value_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.occupancy = rsp_occ_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = new_q;
		rd_en   = 1'b0;
		rd_addr = idx_q;
		case (state_q)
			S_IDLE: begin
				if (accept && req.kind == spq_pkg::KIND_DEQ && count_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			S_EWALK: begin
				if (idx_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_q - IDX_W'(1);
				end
			end
			S_ECMP: begin
				wr_en   = 1'b1;
				wr_data = greater ? rd_data : new_q;
			end
			S_DWALK: begin
				if (!shift_done) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + IDX_W'(1);
				end
			end
			S_DMOVE: begin
				wr_en   = 1'b1;
				wr_data = rd_data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			new_q        <= '0;
			res_value_q  <= '0;
			res_status_q <= spq_pkg::ST_OK;
			rsp_valid_q  <= 1'b0;
			rsp_value_q  <= '0;
			rsp_status_q <= spq_pkg::ST_OK;
			rsp_occ_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_value_q  <= '0;
						res_status_q <= spq_pkg::ST_OK;
						if (req.kind == spq_pkg::KIND_ENQ) begin
							if (count_q == CAP_CNT) begin
								res_status_q <= spq_pkg::ST_OVER;
								state_q      <= S_RESP;
							end else begin
								new_q   <= '{value: req.value_in, prio: req.priority_in};
								idx_q   <= IDX_W'(count_q);
								state_q <= S_EWALK;
							end
						end else begin
							if (count_q == '0) begin
								res_status_q <= spq_pkg::ST_UNDER;
								state_q      <= S_RESP;
							end else begin
								idx_q   <= '0;
								state_q <= S_DREAD;
							end
						end
					end
				end
				S_EWALK: begin
					if (idx_q == '0) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_RESP;
					end else begin
						state_q <= S_ECMP;
					end
				end
				S_ECMP: begin
					if (greater) begin
						idx_q   <= idx_q - IDX_W'(1);
						state_q <= S_EWALK;
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_RESP;
					end
				end
				S_DREAD: begin
					res_value_q <= rd_data.value;
					state_q     <= S_DWALK;
				end
				S_DWALK: begin
					if (shift_done) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_RESP;
					end else begin
						state_q <= S_DMOVE;
					end
				end
				S_DMOVE: begin
					idx_q   <= idx_q + IDX_W'(1);
					state_q <= S_DWALK;
				end
				S_RESP: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (load) begin
				rsp_valid_q  <= 1'b1;
				rsp_value_q  <= res_value_q;
				rsp_status_q <= res_status_q;
				rsp_occ_q    <= count_q;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("request beat accepted but sequencer stayed idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count above capacity");

	a_over_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res_status_q == spq_pkg::ST_OVER) |-> count_q == CAP_CNT)
		else $error("overflow reported on a queue that is not full");

	a_under_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res_status_q == spq_pkg::ST_UNDER) |-> count_q == '0)
		else $error("underflow reported on a queue that is not empty");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> CNT_W'(wr_addr) <= count_q)
		else $error("store write beyond the filled part of the list");
`endif

endmodule

FILE: src/sorted_priority_queue_top.sv
// Sorted priority queue with a fixed capacity: enqueue inserts by priority, FIFO among ties,
// dequeue returns the front word. Depends on spq_pkg, spq_if.sv, spq_store and spq_seq.
//
// Each request beat yields one response beat. The block takes one request at a time; the
// sequencer walks the entry store (one read port, one write port) through one comparator,
// one slot at a time. An enqueue walks from the back past every stored entry of higher
// priority value; a dequeue reads the front word and moves each remaining entry down one
// slot; an overflow or underflow goes straight to the response. A waiting response does not
// hold up the walk.
`timescale 1ns / 1ps

module sorted_priority_queue_top #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(CAPACITY);

	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	spq_pkg::spq_entry_t wr_data;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	spq_pkg::spq_entry_t rd_data;

	spq_store #(
		.CAPACITY (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	spq_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
